// ----- sv/bvg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge package
// Shared types, register codes, reset values and the control store program.
// ----------------------------------------------------------------------------
package bvg_pkg;

   localparam int MV_W   = 13;
   localparam int PCT_W  = 7;
   localparam int CNT_W  = 8;
   localparam int REM_W  = 20;
   localparam int QB_W   = 3;
   localparam int STEP_W = 2;
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] REG_MIN_MV       = 3'd0;
   localparam logic [IDX_W-1:0] REG_MAX_MV       = 3'd1;
   localparam logic [IDX_W-1:0] REG_LOW_PERCENT  = 3'd2;
   localparam logic [IDX_W-1:0] REG_LOW_LIMIT    = 3'd3;
   localparam logic [IDX_W-1:0] REG_FULL_PERCENT = 3'd4;
   localparam logic [IDX_W-1:0] REG_NOTIFY_MV    = 3'd5;

   localparam logic [MV_W-1:0]  RST_MIN_MV       = 13'd3600;
   localparam logic [MV_W-1:0]  RST_MAX_MV       = 13'd4300;
   localparam logic [PCT_W-1:0] RST_LOW_PERCENT  = 7'd50;
   localparam logic [CNT_W-1:0] RST_LOW_LIMIT    = 8'd2;
   localparam logic [PCT_W-1:0] RST_FULL_PERCENT = 7'd95;
   localparam logic [MV_W-1:0]  RST_NOTIFY_MV    = 13'd4000;

   localparam logic [PCT_W-1:0] PCT_FULL_SCALE = 7'd100;
   localparam logic [6:0]       MV_SCALE       = 7'd125;
   localparam logic [MV_W-1:0]  MV_OFFSET      = 13'd507;
   localparam logic [2:0]       MV_ROUND_MIN   = 3'd2;
   localparam logic [QB_W-1:0]  DIV_LAST_BIT   = 3'd6;

   localparam logic [1:0] ST_DISCHARGING  = 2'd0;
   localparam logic [1:0] ST_CHARGING     = 2'd1;
   localparam logic [1:0] ST_NOT_CHARGING = 2'd2;
   localparam logic [1:0] ST_FULL         = 2'd3;

   localparam logic [1:0] OP_MV     = 2'd0;
   localparam logic [1:0] OP_CLASS  = 2'd1;
   localparam logic [1:0] OP_DIV    = 2'd2;
   localparam logic [1:0] OP_UPDATE = 2'd3;

   localparam logic [1:0] COND_NEXT = 2'd0;
   localparam logic [1:0] COND_SKIP = 2'd1;
   localparam logic [1:0] COND_LOOP = 2'd2;

   localparam logic [STEP_W-1:0] STEP_MV     = 2'd0;
   localparam logic [STEP_W-1:0] STEP_CLASS  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_DIV    = 2'd2;
   localparam logic [STEP_W-1:0] STEP_UPDATE = 2'd3;

   typedef struct packed {
      logic [7:0] adc_code;
      logic       online;
      logic       mode;
      logic       key_press;
   } req_type;

   typedef struct packed {
      logic [MV_W-1:0]  vcell_mv;
      logic [PCT_W-1:0] soc_percent;
      logic [1:0]       status;
      logic             charge_enable;
      logic             changed;
      logic             poweroff_request;
   } rsp_type;

   typedef struct packed {
      logic [MV_W-1:0]  min_mv;
      logic [MV_W-1:0]  max_mv;
      logic [PCT_W-1:0] low_percent;
      logic [CNT_W-1:0] low_count_limit;
      logic [PCT_W-1:0] full_percent;
      logic [MV_W-1:0]  notify_mv;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctrl_type;

   typedef struct packed {
      logic div_skip;
      logic div_more;
   } flags_type;

   function automatic ctrl_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '0;
      case (step)
         STEP_MV: begin
            w.op = OP_MV; w.cond = COND_NEXT; w.target = STEP_CLASS; w.last = 1'b0;
         end
         STEP_CLASS: begin
            w.op = OP_CLASS; w.cond = COND_SKIP; w.target = STEP_UPDATE; w.last = 1'b0;
         end
         STEP_DIV: begin
            w.op = OP_DIV; w.cond = COND_LOOP; w.target = STEP_DIV; w.last = 1'b0;
         end
         STEP_UPDATE: begin
            w.op = OP_UPDATE; w.cond = COND_NEXT; w.target = STEP_MV; w.last = 1'b1;
         end
         default: begin
            w.op = OP_UPDATE; w.cond = COND_NEXT; w.target = STEP_MV; w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/bvg_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge sequencer
// Step counter over the control store, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module bvg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                hold,
   input  bvg_pkg::flags_type  flags,
   output bvg_pkg::ctrl_type   ctrl,
   output logic                run,
   output logic                busy
);

   logic                       busy_ff, busy_in;
   logic [bvg_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       jump;

   always_comb begin
      ctrl = bvg_pkg::rom_word(step_ff);
      run  = busy_ff && !(ctrl.last && hold);
      case (ctrl.cond)
         bvg_pkg::COND_SKIP: jump = flags.div_skip;
         bvg_pkg::COND_LOOP: jump = flags.div_more;
         default:            jump = 1'b0;
      endcase
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = bvg_pkg::STEP_MV;
      end else if (run) begin
         if (ctrl.last) begin
            busy_in = 1'b0;
            step_in = bvg_pkg::STEP_MV;
         end else if (jump) begin
            step_in = ctrl.target;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= bvg_pkg::STEP_MV;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- sv/bvg_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge datapath
// Voltage conversion, range check, shift-subtract divider and gauge state.
// ----------------------------------------------------------------------------
module bvg_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bvg_pkg::req_type    req,
   input  bvg_pkg::cfg_type    cfg,
   input  bvg_pkg::ctrl_type   ctrl,
   input  logic                run,
   output bvg_pkg::flags_type  flags,
   output bvg_pkg::rsp_type    result
);

   bvg_pkg::req_type                req_ff;
   logic [bvg_pkg::MV_W-1:0]        mv_ff, mv_in;
   logic [bvg_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [bvg_pkg::REM_W-1:0]       dsh_ff, dsh_in;
   logic [bvg_pkg::PCT_W-1:0]       q_ff, q_in;
   logic [bvg_pkg::QB_W-1:0]        cnt_ff, cnt_in;
   logic                            below_ff, below_in;
   logic                            above_ff, above_in;
   logic [bvg_pkg::CNT_W-1:0]       low_count_ff, low_count_in;
   logic                            chg_en_ff, chg_en_in;
   logic [bvg_pkg::PCT_W-1:0]       last_soc_ff, last_soc_in;
   logic                            last_online_ff, last_online_in;

   logic [14:0]                     scaled;
   logic [bvg_pkg::MV_W-1:0]        mv_calc;
   logic                            is_below, is_above, degenerate;
   logic [bvg_pkg::MV_W-1:0]        span, offs;
   logic [bvg_pkg::REM_W-1:0]       prod;
   logic                            fits;
   logic [bvg_pkg::CNT_W-1:0]       lc_inc, lc_new;
   logic                            en_new, soc_low;
   logic [1:0]                      status;
   logic                            changed, poff;

   always_comb begin
      scaled  = 15'(req_ff.adc_code) * 15'(bvg_pkg::MV_SCALE);
      mv_calc = 13'(scaled[14:3]) + bvg_pkg::MV_OFFSET
              + 13'(scaled[2:0] >= bvg_pkg::MV_ROUND_MIN);

      is_below   = mv_ff < cfg.min_mv;
      is_above   = mv_ff > cfg.max_mv;
      degenerate = !(cfg.max_mv > cfg.min_mv);
      span       = cfg.max_mv - cfg.min_mv;
      offs       = mv_ff - cfg.min_mv;
      prod       = 20'(offs) * 20'(bvg_pkg::PCT_FULL_SCALE);
      fits       = rem_ff >= dsh_ff;

      flags.div_skip = is_below || is_above || degenerate;
      flags.div_more = cnt_ff != '0;

      lc_inc  = (low_count_ff == '1) ? low_count_ff : low_count_ff + 8'd1;
      soc_low = q_ff < cfg.low_percent;
      if (below_ff) begin
         lc_new = lc_inc;
      end else if (above_ff) begin
         lc_new = '0;
      end else if (soc_low) begin
         lc_new = lc_inc;
      end else if (low_count_ff != '0) begin
         lc_new = low_count_ff - 8'd1;
      end else begin
         lc_new = low_count_ff;
      end
      en_new = (above_ff && !below_ff) ? 1'b0 : chg_en_ff;

      if (q_ff > cfg.full_percent) begin
         status = bvg_pkg::ST_FULL;
      end else if (req_ff.online) begin
         status = en_new ? bvg_pkg::ST_CHARGING : bvg_pkg::ST_NOT_CHARGING;
      end else begin
         status = bvg_pkg::ST_DISCHARGING;
      end

      if (req_ff.mode) begin
         changed = 1'b1;
         poff    = (mv_ff < cfg.notify_mv) || req_ff.key_press;
      end else begin
         changed = (q_ff != last_soc_ff) || (en_new != chg_en_ff)
                 || (req_ff.online != last_online_ff);
         poff    = soc_low && (lc_new > cfg.low_count_limit);
      end

      result.vcell_mv         = mv_ff;
      result.soc_percent      = q_ff;
      result.status           = status;
      result.charge_enable    = en_new;
      result.changed          = changed;
      result.poweroff_request = poff;

      mv_in          = mv_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      q_in           = q_ff;
      cnt_in         = cnt_ff;
      below_in       = below_ff;
      above_in       = above_ff;
      low_count_in   = low_count_ff;
      chg_en_in      = chg_en_ff;
      last_soc_in    = last_soc_ff;
      last_online_in = last_online_ff;

      if (run) begin
         case (ctrl.op)
            bvg_pkg::OP_MV: begin
               mv_in = mv_calc;
            end
            bvg_pkg::OP_CLASS: begin
               below_in = is_below;
               above_in = is_above;
               rem_in   = prod;
               dsh_in   = {1'b0, span, 6'b0};
               cnt_in   = bvg_pkg::DIV_LAST_BIT;
               q_in     = is_below ? '0 : bvg_pkg::PCT_FULL_SCALE;
               if (!flags.div_skip) begin
                  q_in = '0;
               end
            end
            bvg_pkg::OP_DIV: begin
               if (fits) begin
                  rem_in = rem_ff - dsh_ff;
               end
               q_in   = {q_ff[bvg_pkg::PCT_W-2:0], fits};
               dsh_in = dsh_ff >> 1;
               cnt_in = cnt_ff - 3'd1;
            end
            bvg_pkg::OP_UPDATE: begin
               low_count_in   = lc_new;
               chg_en_in      = en_new;
               last_soc_in    = q_ff;
               last_online_in = req_ff.online;
            end
            default: begin
               mv_in = mv_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= req;
      end
      mv_ff    <= mv_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      below_ff <= below_in;
      above_ff <= above_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff   <= '0;
         chg_en_ff      <= 1'b1;
         last_soc_ff    <= '0;
         last_online_ff <= 1'b0;
      end else begin
         low_count_ff   <= low_count_in;
         chg_en_ff      <= chg_en_in;
         last_soc_ff    <= last_soc_in;
         last_online_ff <= last_online_in;
      end
   end

endmodule

// ----- sv/battery_voltage_gauge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge
// Converts a battery converter code to millivolts and keeps charge state.
// ----------------------------------------------------------------------------
// A request on the req_ channel carries one converter code with the supply,
// mode and key flags; each request yields exactly one response on rsp_.
// The block handles one request at a time: req_stall is high from the
// accepting edge until the response has been written to the output register.
// A request whose voltage lies within the range, ends included, with the
// maximum above the minimum runs the divider; any other skips it. The divider
// retires one quotient bit per cycle. A new request is taken in the cycle
// after the result is registered. The output register holds one response;
// while rsp_stall is high the response holds and a following request waits
// at its final step. Registers are written over the csr_ port, which is
// always ready; the user must write them only while the block is idle, as the
// block itself does not enforce it. Synchronous reset loads the register
// defaults, clears the low-battery counter and history, enables charging and
// empties the output.
// ----------------------------------------------------------------------------
module battery_voltage_gauge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bvg_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bvg_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bvg_pkg::IDX_W-1:0]     csr_index,
   input  logic [bvg_pkg::MV_W-1:0]      csr_wdata
);

   bvg_pkg::cfg_type   cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bvg_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   bvg_pkg::ctrl_type  ctrl;
   bvg_pkg::flags_type flags;
   bvg_pkg::rsp_type   result;
   logic               run, busy, start, hold, done;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign hold      = rsp_valid_ff && rsp_stall;
   assign done      = run && ctrl.last;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bvg_pkg::REG_MIN_MV:       cfg_in.min_mv          = csr_wdata;
            bvg_pkg::REG_MAX_MV:       cfg_in.max_mv          = csr_wdata;
            bvg_pkg::REG_LOW_PERCENT:  cfg_in.low_percent     = csr_wdata[6:0];
            bvg_pkg::REG_LOW_LIMIT:    cfg_in.low_count_limit = csr_wdata[7:0];
            bvg_pkg::REG_FULL_PERCENT: cfg_in.full_percent    = csr_wdata[6:0];
            bvg_pkg::REG_NOTIFY_MV:    cfg_in.notify_mv       = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_mv          <= bvg_pkg::RST_MIN_MV;
         cfg_ff.max_mv          <= bvg_pkg::RST_MAX_MV;
         cfg_ff.low_percent     <= bvg_pkg::RST_LOW_PERCENT;
         cfg_ff.low_count_limit <= bvg_pkg::RST_LOW_LIMIT;
         cfg_ff.full_percent    <= bvg_pkg::RST_FULL_PERCENT;
         cfg_ff.notify_mv       <= bvg_pkg::RST_NOTIFY_MV;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bvg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .hold  (hold),
      .flags (flags),
      .ctrl  (ctrl),
      .run   (run),
      .busy  (busy)
   );

   bvg_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .cfg    (cfg_ff),
      .ctrl   (ctrl),
      .run    (run),
      .flags  (flags),
      .result (result)
   );

endmodule

// ----- tb/sv/gauge_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge checker
// Follows register writes, predicts the response of every accepted request
// from a private copy of the registers and gauge state, and compares each
// accepted response field by field with the oldest prediction in line.
// ----------------------------------------------------------------------------
module gauge_checker
   import bvg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [MV_W-1:0]       csr_wdata,
   output int                    pending,
   output int                    errors
);

   localparam int unsigned UV_PER_CODE = 15625;
   localparam int unsigned UV_BIAS     = 507812;
   localparam int unsigned UV_PER_MV   = 1000;
   localparam int unsigned FULL_SCALE  = 100;

   cfg_type          settings;
   logic [CNT_W-1:0] low_count;
   logic             charge_on;
   logic [PCT_W-1:0] prev_soc;
   logic             prev_online;
   rsp_type          readings_q[$];
   int               error_total;

   function automatic rsp_type predict_reading(input req_type r);
      int unsigned code;
      int unsigned mv;
      int unsigned soc;
      logic        old_on;
      rsp_type     p;
      old_on = charge_on;
      code = r.adc_code;
      mv = (code * UV_PER_CODE + UV_BIAS) / UV_PER_MV;
      if (mv < settings.min_mv) begin
         soc = 0;
         if (low_count != '1) low_count++;
      end else if (mv > settings.max_mv) begin
         soc = FULL_SCALE;
         charge_on = 1'b0;
         low_count = '0;
      end else begin
         if (settings.max_mv > settings.min_mv)
            soc = (mv - settings.min_mv) * FULL_SCALE / (settings.max_mv - settings.min_mv);
         else
            soc = FULL_SCALE;
         if (soc < settings.low_percent) begin
            if (low_count != '1) low_count++;
         end else if (low_count != '0) begin
            low_count--;
         end
      end
      if (r.online)
         p.status = charge_on ? ST_CHARGING : ST_NOT_CHARGING;
      else
         p.status = ST_DISCHARGING;
      if (soc > settings.full_percent) p.status = ST_FULL;
      if (r.mode) begin
         p.changed = 1'b1;
         p.poweroff_request = (mv < settings.notify_mv) || r.key_press;
      end else begin
         p.changed = (soc != prev_soc) || (old_on != charge_on) || (r.online != prev_online);
         p.poweroff_request = (soc < settings.low_percent) &&
                              (low_count > settings.low_count_limit);
      end
      prev_soc = PCT_W'(soc);
      prev_online = r.online;
      p.vcell_mv = MV_W'(mv);
      p.soc_percent = PCT_W'(soc);
      p.charge_enable = charge_on;
      return p;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         if (error_total < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         settings.min_mv = RST_MIN_MV;
         settings.max_mv = RST_MAX_MV;
         settings.low_percent = RST_LOW_PERCENT;
         settings.low_count_limit = RST_LOW_LIMIT;
         settings.full_percent = RST_FULL_PERCENT;
         settings.notify_mv = RST_NOTIFY_MV;
         low_count = '0;
         charge_on = 1'b1;
         prev_soc = '0;
         prev_online = 1'b0;
         readings_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_MV:       settings.min_mv = csr_wdata;
               REG_MAX_MV:       settings.max_mv = csr_wdata;
               REG_LOW_PERCENT:  settings.low_percent = csr_wdata[PCT_W-1:0];
               REG_LOW_LIMIT:    settings.low_count_limit = csr_wdata[CNT_W-1:0];
               REG_FULL_PERCENT: settings.full_percent = csr_wdata[PCT_W-1:0];
               REG_NOTIFY_MV:    settings.notify_mv = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) readings_q.push_back(predict_reading(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (readings_q.size() == 0) begin
               if (error_total < 10) $display("%0t: response with no request in flight", $time);
               error_total++;
            end else begin
               want = readings_q.pop_front();
               check_field("vcell_mv", 16'(want.vcell_mv), 16'(rsp_data.vcell_mv));
               check_field("soc_percent", 16'(want.soc_percent), 16'(rsp_data.soc_percent));
               check_field("status", 16'(want.status), 16'(rsp_data.status));
               check_field("charge_enable", 16'(want.charge_enable),
                           16'(rsp_data.charge_enable));
               check_field("changed", 16'(want.changed), 16'(rsp_data.changed));
               check_field("poweroff_request", 16'(want.poweroff_request),
                           16'(rsp_data.poweroff_request));
            end
         end
      end
      pending <= readings_q.size();
      errors <= error_total;
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge testbench
// Drives directed requests at the register and voltage extremes, then runs
// random phases under changing register settings with random idle bursts on
// both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import bvg_pkg::*;

   localparam int PHASES        = 9;
   localparam int PHASE_REQUESTS = 117;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [MV_W-1:0]  csr_wdata = '0;
   int               pending;
   int               errors;
   bit               req_gaps_on = 1'b1;
   bit               rsp_gaps_on = 1'b1;
   logic [7:0]       cur_code = '0;
   logic             cur_online = 1'b0;

   battery_voltage_gauge dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   gauge_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .errors(errors)
   );

   always #5 clock = ~clock;

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type request_of(input logic [7:0] code, input logic online,
                                          input logic mode, input logic key);
      req_type r;
      r.adc_code = code;
      r.online = online;
      r.mode = mode;
      r.key_press = key;
      return r;
   endfunction

   function automatic logic [7:0] jitter_code(input int center);
      int c;
      c = center + int'($urandom_range(0, 4)) - 2;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return 8'(c);
   endfunction

   function automatic req_type next_request(input cfg_type c);
      case ($urandom_range(0, 9))
         0, 1:    cur_code = jitter_code((int'(c.min_mv) * 1000 - 507812) / 15625);
         2:       cur_code = jitter_code((int'(c.max_mv) * 1000 - 507812) / 15625);
         3:       cur_code = jitter_code((int'(c.notify_mv) * 1000 - 507812) / 15625);
         4, 5:    cur_code = 8'($urandom);
         default: cur_code = jitter_code(int'(cur_code));
      endcase
      if ($urandom_range(0, 7) == 0) cur_online = ~cur_online;
      return request_of(cur_code, cur_online, $urandom_range(0, 3) == 0,
                        $urandom_range(0, 5) == 0);
   endfunction

   function automatic cfg_type pick_setting();
      cfg_type c;
      case ($urandom_range(0, 4))
         0: begin
            c.min_mv = MV_W'($urandom);
            c.max_mv = MV_W'($urandom);
         end
         1: begin
            c.min_mv = MV_W'($urandom_range(500, 4400));
            c.max_mv = c.min_mv + MV_W'($urandom_range(0, 40));
         end
         2: begin
            c.min_mv = MV_W'($urandom_range(0, 1) * 8191);
            c.max_mv = MV_W'($urandom_range(0, 1) * 8191);
         end
         default: begin
            c.min_mv = MV_W'($urandom_range(2800, 3900));
            c.max_mv = c.min_mv + MV_W'($urandom_range(100, 1200));
         end
      endcase
      c.low_percent = ($urandom_range(0, 3) == 0) ? PCT_W'($urandom_range(0, 127))
                                                   : PCT_W'($urandom_range(20, 100));
      c.low_count_limit = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 255))
                                                       : CNT_W'($urandom_range(0, 6));
      c.full_percent = ($urandom_range(0, 3) == 0) ? PCT_W'($urandom_range(0, 127))
                                                    : PCT_W'($urandom_range(80, 100));
      c.notify_mv = ($urandom_range(0, 3) == 0) ? MV_W'($urandom)
                                                 : MV_W'($urandom_range(3000, 4500));
      return c;
   endfunction

   task automatic send_request(input req_type r);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(REG_MIN_MV, c.min_mv);
      write_reg(REG_MAX_MV, c.max_mv);
      write_reg(REG_LOW_PERCENT, {6'($urandom), c.low_percent});
      write_reg(REG_LOW_LIMIT, {5'($urandom), c.low_count_limit});
      write_reg(REG_FULL_PERCENT, {6'($urandom), c.full_percent});
      write_reg(REG_NOTIFY_MV, c.notify_mv);
      if ($urandom_range(0, 1) == 1)
         write_reg(IDX_W'($urandom_range(REG_NOTIFY_MV + 1, (1 << IDX_W) - 1)),
                   MV_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      #6000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      cfg_type c;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(request_of(8'd0, 1'b0, 1'b0, 1'b0));
      send_request(request_of(8'd0, 1'b0, 1'b0, 1'b0));
      send_request(request_of(8'd0, 1'b0, 1'b0, 1'b0));
      send_request(request_of(8'd220, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd242, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd224, 1'b1, 1'b1, 1'b0));
      send_request(request_of(8'd222, 1'b0, 1'b1, 1'b0));
      send_request(request_of(8'd230, 1'b0, 1'b1, 1'b1));
      send_request(request_of(8'd230, 1'b0, 1'b0, 1'b0));
      send_request(request_of(8'd230, 1'b0, 1'b0, 1'b0));
      wait_drained(4);

      c = '{min_mv: 13'd3632, max_mv: 13'd3632, low_percent: 7'd100,
            low_count_limit: 8'd0, full_percent: 7'd100, notify_mv: 13'd0};
      load_settings(c);
      send_request(request_of(8'd199, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd200, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd201, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd200, 1'b1, 1'b0, 1'b0));
      wait_drained(4);

      load_settings('0);
      send_request(request_of(8'd0, 1'b0, 1'b0, 1'b0));
      send_request(request_of(8'd255, 1'b1, 1'b1, 1'b0));
      wait_drained(4);

      load_settings('1);
      send_request(request_of(8'd255, 1'b1, 1'b0, 1'b0));
      send_request(request_of(8'd0, 1'b0, 1'b1, 1'b0));
      send_request(request_of(8'd128, 1'b1, 1'b0, 1'b1));
      wait_drained(4);

      for (int phase = 0; phase < PHASES; phase++) begin
         c = pick_setting();
         load_settings(c);
         if (phase == PHASES - 1) begin
            req_gaps_on = 1'b0;
            rsp_gaps_on <= 1'b0;
         end else begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on <= ($urandom_range(0, 3) != 0);
         end
         for (int i = 0; i < PHASE_REQUESTS; i++) send_request(next_request(c));
         wait_drained(phase == PHASES - 1 ? 20 : 4);
      end

      if (errors == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- battery_voltage_gauge.f -----
sv/bvg_pkg.sv
sv/bvg_seq.sv
sv/bvg_dp.sv
sv/battery_voltage_gauge.sv
tb/sv/gauge_checker.sv
tb/sv/tb.sv
